@@ sv/clcg_pkg.sv @@
package clcg_pkg;

    localparam int unsigned OUT_BITS_DEF    = 32;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned GEN_W  = 15;
    localparam int unsigned FRAC_W = 32;
    localparam int unsigned CFG_W  = 2;
    localparam int unsigned PROD_W = 45;
    localparam int unsigned NUM_W  = 47;
    localparam int unsigned DEN_W  = 45;

    localparam logic [CFG_W-1:0] REG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_W-1:0] REG_SEED_SECOND = 2'd1;
    localparam logic [CFG_W-1:0] REG_SEED_THIRD  = 2'd2;

    localparam logic [GEN_W-1:0] MOD_A = 15'd30269;
    localparam logic [GEN_W-1:0] MOD_B = 15'd30307;
    localparam logic [GEN_W-1:0] MOD_C = 15'd30323;
    localparam logic [7:0]       MUL_A = 8'd171;
    localparam logic [7:0]       MUL_B = 8'd172;
    localparam logic [7:0]       MUL_C = 8'd170;

    // Weights over the common denominator: B*C, A*C, A*B; DEN = A*B*C
    localparam logic [29:0]      WGT_A = 30'd918999161;
    localparam logic [29:0]      WGT_B = 30'd917846887;
    localparam logic [29:0]      WGT_C = 30'd917362583;
    localparam logic [DEN_W-1:0] DEN   = 45'd27817185604309;

    typedef logic [GEN_W-1:0] t_red_tbl [256];

    typedef struct packed {
        logic [GEN_W-1:0] a;
        logic [GEN_W-1:0] b;
        logic [GEN_W-1:0] c;
    } t_draw;

    typedef struct packed {
        logic  vld;
        t_draw draw;
    } t_draw_wr;

    typedef struct packed {
        logic             we;
        logic [CFG_W-1:0] idx;
        logic [GEN_W-1:0] data;
    } t_cfg_wr;

    // Entry i holds (i * 2^15) mod modulus, built by repeated add and fold.
    function automatic t_red_tbl f_red_tbl(input logic [GEN_W-1:0] modulus);
        t_red_tbl   tbl;
        logic [15:0] step;
        logic [15:0] acc;
        step = 16'h8000 - {1'b0, modulus};
        acc  = '0;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = acc[GEN_W-1:0];
            acc    = acc + step;
            if (acc >= {1'b0, modulus}) begin
                acc = acc - {1'b0, modulus};
            end
        end
        return tbl;
    endfunction

    localparam t_red_tbl TBL_A = f_red_tbl(MOD_A);
    localparam t_red_tbl TBL_B = f_red_tbl(MOD_B);
    localparam t_red_tbl TBL_C = f_red_tbl(MOD_C);

    // (mul * g) mod modulus for g below the modulus: fold the bits above
    // 2^15 through the table, then one subtract of the modulus or of twice it.
    function automatic logic [GEN_W-1:0] f_lcg_step(
        input logic [GEN_W-1:0] g,
        input logic [7:0]       mul,
        input logic [GEN_W-1:0] modulus,
        input t_red_tbl         tbl
    );
        logic [22:0] prod;
        logic [16:0] sum;
        logic [16:0] m1;
        logic [16:0] m2;
        prod = 23'(g) * 23'(mul);
        sum  = 17'(tbl[prod[22:15]]) + 17'(prod[14:0]);
        m1   = 17'(modulus);
        m2   = {m1[15:0], 1'b0};
        if (sum >= m2) begin
            sum = sum - m2;
        end else if (sum >= m1) begin
            sum = sum - m1;
        end
        return sum[GEN_W-1:0];
    endfunction

    // A seed may sit at or above its modulus; one subtract brings it below.
    function automatic logic [GEN_W-1:0] f_seed_fold(
        input logic [GEN_W-1:0] v,
        input logic [GEN_W-1:0] modulus
    );
        return (v >= modulus) ? v - modulus : v;
    endfunction

endpackage

@@ sv/clcg_front.sv @@
module clcg_front
    import clcg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    input  logic     i_push,
    input  logic     i_draw_request,
    input  logic     i_full,
    output t_draw_wr o_wr
);

    logic [GEN_W-1:0] r_gen_a;
    logic [GEN_W-1:0] r_gen_b;
    logic [GEN_W-1:0] r_gen_c;
    logic [GEN_W-1:0] n_gen_a;
    logic [GEN_W-1:0] n_gen_b;
    logic [GEN_W-1:0] n_gen_c;
    logic [GEN_W-1:0] step_a;
    logic [GEN_W-1:0] step_b;
    logic [GEN_W-1:0] step_c;
    logic             draw;

    assign step_a = f_lcg_step(r_gen_a, MUL_A, MOD_A, TBL_A);
    assign step_b = f_lcg_step(r_gen_b, MUL_B, MOD_B, TBL_B);
    assign step_c = f_lcg_step(r_gen_c, MUL_C, MOD_C, TBL_C);

    // beats with draw_request low are taken and dropped here
    assign draw = i_push && !i_full && i_draw_request;

    assign o_wr.vld    = draw;
    assign o_wr.draw.a = step_a;
    assign o_wr.draw.b = step_b;
    assign o_wr.draw.c = step_c;

    always_comb begin
        n_gen_a = r_gen_a;
        n_gen_b = r_gen_b;
        n_gen_c = r_gen_c;
        if (draw) begin
            n_gen_a = step_a;
            n_gen_b = step_b;
            n_gen_c = step_c;
        end
        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_SEED_FIRST:  n_gen_a = f_seed_fold(i_cfg.data, MOD_A);
                REG_SEED_SECOND: n_gen_b = f_seed_fold(i_cfg.data, MOD_B);
                REG_SEED_THIRD:  n_gen_c = f_seed_fold(i_cfg.data, MOD_C);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_a <= GEN_W'(1);
            r_gen_b <= GEN_W'(1);
            r_gen_c <= GEN_W'(1);
        end else begin
            r_gen_a <= n_gen_a;
            r_gen_b <= n_gen_b;
            r_gen_c <= n_gen_c;
        end
    end

endmodule

@@ sv/clcg_queue.sv @@
module clcg_queue
    import clcg_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_draw_wr i_wr,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_draw    o_draw
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_draw              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wptr;
    logic [PTR_W-1:0]   n_rptr;
    logic [CNT_W-1:0]   n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_draw  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (i_wr.vld) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        case ({i_wr.vld, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.vld) begin
            r_mem[r_wptr] <= i_wr.draw;
        end
    end

endmodule

@@ sv/clcg_back.sv @@
module clcg_back
    import clcg_pkg::*;
#(
    parameter int unsigned OUT_BITS = OUT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_draw             i_draw,
    output logic              o_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [FRAC_W-1:0] o_uniform_fraction
);

    // stages: weight products, sum, mod DEN, then one quotient bit per stage
    logic                r_v_prod;
    logic                r_v_sum;
    logic                r_v_div [OUT_BITS+1];
    logic [PROD_W-1:0]   r_pa;
    logic [PROD_W-1:0]   r_pb;
    logic [PROD_W-1:0]   r_pc;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_rem [OUT_BITS];
    logic [FRAC_W-1:0]   r_quo [1:OUT_BITS];
    logic [DEN_W:0]      sh    [OUT_BITS];
    logic [DEN_W:0]      red   [OUT_BITS];
    logic                q_bit [OUT_BITS];
    logic [NUM_W-1:0]    num_fold;
    logic                adv;

    // whole pipe moves while the last stage is free or being drained
    assign adv   = !r_v_div[OUT_BITS] || i_pop;
    assign o_pop = adv && !i_empty;

    assign o_empty            = !r_v_div[OUT_BITS];
    assign o_uniform_fraction = r_quo[OUT_BITS];

    always_comb begin
        num_fold = r_num;
        if (r_num >= {DEN, 1'b0}) begin
            num_fold = r_num - {DEN, 1'b0};
        end else if (r_num >= NUM_W'(DEN)) begin
            num_fold = r_num - NUM_W'(DEN);
        end
    end

    always_comb begin
        for (int j = 0; j < OUT_BITS; j++) begin
            sh[j]    = {r_rem[j], 1'b0};
            q_bit[j] = (sh[j] >= {1'b0, DEN});
            red[j]   = q_bit[j] ? sh[j] - {1'b0, DEN} : sh[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            for (int j = 0; j <= OUT_BITS; j++) begin
                r_v_div[j] <= 1'b0;
            end
        end else if (adv) begin
            r_v_prod   <= !i_empty;
            r_v_sum    <= r_v_prod;
            r_v_div[0] <= r_v_sum;
            for (int j = 1; j <= OUT_BITS; j++) begin
                r_v_div[j] <= r_v_div[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pa     <= PROD_W'(i_draw.a) * PROD_W'(WGT_A);
            r_pb     <= PROD_W'(i_draw.b) * PROD_W'(WGT_B);
            r_pc     <= PROD_W'(i_draw.c) * PROD_W'(WGT_C);
            r_num    <= NUM_W'(r_pa) + NUM_W'(r_pb) + NUM_W'(r_pc);
            r_rem[0] <= num_fold[DEN_W-1:0];
            for (int j = 1; j < OUT_BITS; j++) begin
                r_rem[j] <= red[j-1][DEN_W-1:0];
            end
            r_quo[1] <= {{(FRAC_W-1){1'b0}}, q_bit[0]};
            for (int j = 2; j <= OUT_BITS; j++) begin
                r_quo[j] <= {r_quo[j-1][FRAC_W-2:0], q_bit[j-1]};
            end
        end
    end

endmodule

@@ sv/combined_lcg_uniform_generator_unit.sv @@
// Channel  | Direction | Handshake             | Payload
// draw     | in        | push / full           | i_draw_request
// result   | out       | empty / pop           | o_uniform_fraction
// config   | in        | i_cfg_we (no wait)    | i_cfg_idx, i_cfg_wdata
//
// One draw per cycle sustained while full is low; the three generators advance together.
// A result passes the queue write on the accepting edge, then the weight products,
// sum, mod, one stage per fraction bit, and then stands on the ports.
// Synchronous active-low reset; generators come up at 1, queue and pipe empty.
// Back stalls as a whole when the result is not popped; the front keeps taking
// draws until the queue fills, then full rises.
module combined_lcg_uniform_generator_unit
    import clcg_pkg::*;
#(
    parameter int unsigned OUT_BITS    = OUT_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_idx,
    input  logic [GEN_W-1:0]  i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic              i_draw_request,
    output logic              empty,
    input  logic              pop,
    output logic [FRAC_W-1:0] o_uniform_fraction
);

    t_cfg_wr  cfg;
    t_draw_wr q_wr;
    t_draw    q_draw;
    logic     q_empty;
    logic     q_pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_wdata;

    clcg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_push         (push),
        .i_draw_request (i_draw_request),
        .i_full         (full),
        .o_wr           (q_wr)
    );

    clcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_draw  (q_draw)
    );

    clcg_back #(
        .OUT_BITS (OUT_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (q_empty),
        .i_draw             (q_draw),
        .o_pop              (q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_uniform_fraction (o_uniform_fraction)
    );

endmodule

@@ tb/tb.sv @@
module tb;
    import clcg_pkg::*;

    localparam int unsigned          OUT_W        = OUT_BITS_DEF;
    localparam int unsigned          MOD_X        = 30269;
    localparam int unsigned          MOD_Y        = 30307;
    localparam int unsigned          MOD_Z        = 30323;
    localparam int unsigned          MUL_X        = 171;
    localparam int unsigned          MUL_Y        = 172;
    localparam int unsigned          MUL_Z        = 170;
    localparam longint unsigned      DEN_XYZ      = longint'(MOD_X) * MOD_Y * MOD_Z;
    localparam logic [CFG_W-1:0]     REG_UNUSED   = CFG_W'(3);
    localparam int unsigned          DRAIN_CYCLES = OUT_W + 4 + 24;
    localparam int unsigned          CYCLE_LIMIT  = 200000;
    localparam int unsigned          SEG_DRAWS    = 94;

    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              i_cfg_we           = 1'b0;
    logic [CFG_W-1:0]  i_cfg_idx          = '0;
    logic [GEN_W-1:0]  i_cfg_wdata        = '0;
    logic              push               = 1'b0;
    logic              full;
    logic              i_draw_request     = 1'b0;
    logic              empty;
    logic              pop                = 1'b0;
    logic [FRAC_W-1:0] o_uniform_fraction;

    bit                pending_draws[$];
    logic [FRAC_W-1:0] expected_fracs[$];
    bit [GEN_W-1:0]    gen_x = 15'd1;
    bit [GEN_W-1:0]    gen_y = 15'd1;
    bit [GEN_W-1:0]    gen_z = 15'd1;
    int unsigned       send_idle_pct = 7;
    int unsigned       recv_idle_pct = 79;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;

    combined_lcg_uniform_generator_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .push               (push),
        .full               (full),
        .i_draw_request     (i_draw_request),
        .empty              (empty),
        .pop                (pop),
        .o_uniform_fraction (o_uniform_fraction)
    );

    always #5 i_clk = ~i_clk;

    // Step all three generators, then long-divide the exact remainder of the
    // weighted sum over the common denominator to get the fraction bits.
    function automatic logic [FRAC_W-1:0] next_uniform_fraction();
        longint unsigned num;
        longint unsigned rem;
        logic [FRAC_W-1:0] q;
        gen_x = GEN_W'((MUL_X * gen_x) % MOD_X);
        gen_y = GEN_W'((MUL_Y * gen_y) % MOD_Y);
        gen_z = GEN_W'((MUL_Z * gen_z) % MOD_Z);
        num = longint'(gen_x) * MOD_Y * MOD_Z
            + longint'(gen_y) * MOD_X * MOD_Z
            + longint'(gen_z) * MOD_X * MOD_Y;
        rem = num % DEN_XYZ;
        q   = '0;
        for (int i = 0; i < OUT_W; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= DEN_XYZ) begin
                rem  = rem - DEN_XYZ;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [GEN_W-1:0] pick_seed(int unsigned modulus);
        case ($urandom_range(9))
            0: return '0;
            1: return GEN_W'(modulus - 1);
            2: return '1;
            3: return GEN_W'(modulus);
            default: return GEN_W'($urandom_range(modulus - 1, 1));
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [FRAC_W-1:0] exp_val,
                                   logic [FRAC_W-1:0] got_val);
        $display("mismatch: %s expected %h got %h", what, exp_val, got_val);
        mismatch_count++;
    endtask

    task automatic write_seed(logic [CFG_W-1:0] idx, logic [GEN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_all_seeds(logic [GEN_W-1:0] sx, logic [GEN_W-1:0] sy,
                                   logic [GEN_W-1:0] sz);
        write_seed(REG_SEED_FIRST, sx);
        write_seed(REG_SEED_SECOND, sy);
        write_seed(REG_SEED_THIRD, sz);
    endtask

    // Roughly one beat in ten carries no request; only requests count.
    task automatic queue_draws(int unsigned n_req);
        int unsigned n = 0;
        while (n < n_req) begin
            if ($urandom_range(9) == 0) begin
                pending_draws.push_back(1'b0);
            end else begin
                pending_draws.push_back(1'b1);
                n++;
            end
        end
    endtask

    // Sender holds off until every beat is in and every result is out, then
    // idles for the DRAIN_CYCLES margin; no-request beats never enter the pipe.
    task automatic wait_drained();
        while (pending_draws.size() != 0 || expected_fracs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (pending_draws.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                push           <= 1'b1;
                i_draw_request <= pending_draws[0];
            end else begin
                push <= 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [FRAC_W-1:0] exp_frac;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_fracs.size() == 0) begin
                    report_mismatch("unexpected beat", '0, o_uniform_fraction);
                end else begin
                    exp_frac = expected_fracs.pop_front();
                    if (o_uniform_fraction !== exp_frac) begin
                        report_mismatch("uniform_fraction", exp_frac, o_uniform_fraction);
                    end
                end
            end
            if (push && !full) begin
                if (i_draw_request) begin
                    expected_fracs.push_back(next_uniform_fraction());
                end
                void'(pending_draws.pop_front());
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SEED_FIRST:  gen_x = i_cfg_wdata;
                    REG_SEED_SECOND: gen_y = i_cfg_wdata;
                    REG_SEED_THIRD:  gen_z = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset seeds, plus a beat with no request
        pending_draws.push_back(1'b1);
        pending_draws.push_back(1'b1);
        pending_draws.push_back(1'b0);
        pending_draws.push_back(1'b1);
        wait_drained();

        write_all_seeds(15'd30268, 15'd30306, 15'd30322);
        queue_draws(2);
        wait_drained();

        // all generators stuck at zero: sum is an integer, fraction is 0
        write_all_seeds('0, '0, '0);
        queue_draws(2);
        wait_drained();

        write_all_seeds('1, '1, '1);
        queue_draws(2);
        wait_drained();

        // unused index must not disturb anything; first and third seeds at the modulus
        write_seed(REG_UNUSED, '1);
        write_all_seeds(GEN_W'(MOD_X), '0, GEN_W'(MOD_Z));
        write_seed(REG_UNUSED, '0);
        queue_draws(2);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                write_all_seeds(pick_seed(MOD_X), pick_seed(MOD_Y), pick_seed(MOD_Z));
                if ($urandom_range(3) == 0) begin
                    write_seed(REG_UNUSED, GEN_W'($urandom));
                end
                queue_draws(SEG_DRAWS);
                wait_drained();
            end
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/clcg_pkg.sv
sv/clcg_front.sv
sv/clcg_queue.sv
sv/clcg_back.sv
sv/combined_lcg_uniform_generator_unit.sv
tb/tb.sv
